// ===== hw/rtl/hash_table_with_overflow_area_macros.svh =====
// assertion macros shared by the hash table block
`ifndef HASH_TABLE_WITH_OVERFLOW_AREA_MACROS_SVH
`define HASH_TABLE_WITH_OVERFLOW_AREA_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define HTOA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define HTOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/htoa_pkg.sv =====
// shared types, codes and constants of the hash table with overflow area
`default_nettype none

package htoa_pkg;

  // default sizes
  localparam int unsigned DEF_PRIMARY_SLOTS  = 8;
  localparam int unsigned DEF_OVERFLOW_SLOTS = 8;
  localparam int unsigned DEF_KEY_CHARS      = 8;

  // fixed field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned REC_W    = 8;
  localparam int unsigned STATUS_W = 3;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_PRIMARY   = 3'd0;
  localparam status_t ST_OVERFLOW  = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  // where the result index comes from
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_PRIMARY,
    SEL_OVERFLOW
  } idx_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     mod_step;
    logic     prim_read;
    logic     prim_write;
    logic     ovf_append;
    logic     scan_start;
    logic     scan_read;
    logic     scan_next;
    logic     res_set;
    status_t  res_status;
    idx_sel_t res_sel;
    logic     out_load;
  } htoa_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic op_search;
    logic mod_last;
    logic prim_valid;
    logic prim_hit;
    logic ovf_room;
    logic ovf_empty;
    logic ovf_hit;
    logic scan_last;
    logic out_busy;
  } htoa_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/htoa_dp.sv =====
// datapath: hash unit, primary and overflow stores, result and output registers
`default_nettype none

module htoa_dp #(
  parameter int unsigned PRIMARY_SLOTS  = htoa_pkg::DEF_PRIMARY_SLOTS,
  parameter int unsigned OVERFLOW_SLOTS = htoa_pkg::DEF_OVERFLOW_SLOTS,
  parameter int unsigned KEY_CHARS      = htoa_pkg::DEF_KEY_CHARS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire htoa_pkg::htoa_cmd_t             cmd,
  output htoa_pkg::htoa_stat_t                 stat,
  input  wire logic                            operation,
  input  wire logic [htoa_pkg::KEY_W-1:0]      key,
  input  wire logic [htoa_pkg::REC_W-1:0]      record_index,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [htoa_pkg::STATUS_W-1:0]        status,
  output logic [htoa_pkg::REC_W-1:0]           result_index
);
  import htoa_pkg::*;

  localparam int unsigned KEY_BITS = 8 * KEY_CHARS;
  localparam int unsigned SUM_MAX  = KEY_CHARS * 255;
  localparam int unsigned SUM_W    = $clog2(SUM_MAX + 1);
  localparam int unsigned SLOT_W   = $clog2(PRIMARY_SLOTS);
  localparam int unsigned SHIFT    = SUM_W + SLOT_W;
  localparam int unsigned PROD_W   = SUM_W + SHIFT;
  localparam int unsigned RECIP    = ((32'd1 << SHIFT) + PRIMARY_SLOTS - 1) / PRIMARY_SLOTS;
  localparam int unsigned CNT_W    = $clog2(OVERFLOW_SLOTS + 1);
  localparam int unsigned OA_W     = (OVERFLOW_SLOTS > 1) ? $clog2(OVERFLOW_SLOTS) : 1;
  localparam logic [SHIFT-1:0] RECIP_C = SHIFT'(RECIP);
  localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(PRIMARY_SLOTS);

  // captured transaction
  logic                op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [REC_W-1:0]    rec_q;

  // hash unit: byte sum then reciprocal multiplication and multiply-subtract
  logic [SUM_W-1:0]  sum_in;
  logic [SUM_W-1:0]  rem;
  logic              mod_phase;
  logic [SUM_W-1:0]  quot;
  logic [PROD_W-1:0] prod;
  logic [SLOT_W-1:0] slot;

  // primary area
  logic [PRIMARY_SLOTS-1:0] prim_valid;
  logic [KEY_BITS-1:0]      prim_key_mem [PRIMARY_SLOTS];
  logic [REC_W-1:0]         prim_idx_mem [PRIMARY_SLOTS];
  logic                     pv_rd;
  logic [KEY_BITS-1:0]      pk_rd;
  logic [REC_W-1:0]         pi_rd;

  // overflow area
  logic [KEY_BITS-1:0] ovf_key_mem [OVERFLOW_SLOTS];
  logic [REC_W-1:0]    ovf_idx_mem [OVERFLOW_SLOTS];
  logic [CNT_W-1:0]    ovf_count;
  logic [OA_W-1:0]     scan;
  logic [KEY_BITS-1:0] ok_rd;
  logic [REC_W-1:0]    oi_rd;

  // pending result
  status_t          res_status;
  logic [REC_W-1:0] res_index;

  // byte sum of the used key characters
  always_comb begin
    sum_in = '0;
    for (int b = 0; b < KEY_CHARS; b++) begin
      sum_in = sum_in + SUM_W'(key[8*b +: 8]);
    end
  end

  // quotient estimate, exact over the whole sum range
  assign prod = PROD_W'(rem) * PROD_W'(RECIP_C);
  assign slot = rem[SLOT_W-1:0];

  // capture and hash registers: quotient first, remainder second
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q      <= operation;
      key_q     <= key[KEY_BITS-1:0];
      rec_q     <= record_index;
      rem       <= sum_in;
      mod_phase <= 1'b0;
    end else if (cmd.mod_step) begin
      if (!mod_phase) begin
        quot      <= prod[PROD_W-1:SHIFT];
        mod_phase <= 1'b1;
      end else begin
        rem <= rem - quot * DIVISOR;
      end
    end
  end

  // primary valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      prim_valid <= '0;
    end else if (cmd.prim_write) begin
      prim_valid[slot] <= 1'b1;
    end
  end

  // primary store, registered read
  always_ff @(posedge clk) begin
    if (cmd.prim_write) begin
      prim_key_mem[slot] <= key_q;
      prim_idx_mem[slot] <= rec_q;
    end
    if (cmd.prim_read) begin
      pv_rd <= prim_valid[slot];
      pk_rd <= prim_key_mem[slot];
      pi_rd <= prim_idx_mem[slot];
    end
  end

  // overflow fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_count <= '0;
    end else if (cmd.ovf_append) begin
      ovf_count <= ovf_count + CNT_W'(1);
    end
  end

  // overflow store, registered read at the scan pointer
  always_ff @(posedge clk) begin
    if (cmd.ovf_append) begin
      ovf_key_mem[ovf_count[OA_W-1:0]] <= key_q;
      ovf_idx_mem[ovf_count[OA_W-1:0]] <= rec_q;
    end
    if (cmd.scan_read) begin
      ok_rd <= ovf_key_mem[scan];
      oi_rd <= ovf_idx_mem[scan];
    end
  end

  // scan pointer
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan <= '0;
    end else if (cmd.scan_next) begin
      scan <= scan + OA_W'(1);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        SEL_PRIMARY:  res_index <= pi_rd;
        SEL_OVERFLOW: res_index <= oi_rd;
        default:      res_index <= '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= res_status;
      result_index <= res_index;
    end
  end

  // status towards the controller
  always_comb begin
    stat            = '0;
    stat.op_search  = (op_q == OP_SEARCH);
    stat.mod_last   = mod_phase;
    stat.prim_valid = pv_rd;
    stat.prim_hit   = pv_rd && (pk_rd == key_q);
    stat.ovf_room   = (ovf_count < CNT_W'(OVERFLOW_SLOTS));
    stat.ovf_empty  = (ovf_count == '0);
    stat.ovf_hit    = (ok_rd == key_q);
    stat.scan_last  = ((CNT_W'(scan) + CNT_W'(1)) == ovf_count);
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/htoa_ctrl.sv =====
// controller: sequences hash, primary check, overflow append or scan, result
`default_nettype none

module htoa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output htoa_pkg::htoa_cmd_t       cmd,
  input  wire htoa_pkg::htoa_stat_t stat
);
  import htoa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PRIM_RD,
    S_PRIM_CHK,
    S_OVF_RD,
    S_OVF_CHK,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = S_PRIM_RD;
        end
      end
      S_PRIM_RD: begin
        cmd.prim_read = 1'b1;
        state_next    = S_PRIM_CHK;
      end
      S_PRIM_CHK: begin
        state_next  = S_DONE;
        cmd.res_set = 1'b1;
        cmd.res_sel = SEL_NONE;
        if (!stat.op_search) begin
          if (!stat.prim_valid) begin
            cmd.prim_write = 1'b1;
            cmd.res_status = ST_PRIMARY;
          end else if (stat.ovf_room) begin
            cmd.ovf_append = 1'b1;
            cmd.res_status = ST_OVERFLOW;
          end else begin
            cmd.res_status = ST_FULL;
          end
        end else if (stat.prim_hit) begin
          cmd.res_status = ST_FOUND;
          cmd.res_sel    = SEL_PRIMARY;
        end else if (stat.ovf_empty) begin
          cmd.res_status = ST_NOT_FOUND;
        end else begin
          cmd.res_set    = 1'b0;
          cmd.scan_start = 1'b1;
          state_next     = S_OVF_RD;
        end
      end
      S_OVF_RD: begin
        cmd.scan_read = 1'b1;
        state_next    = S_OVF_CHK;
      end
      S_OVF_CHK: begin
        if (stat.ovf_hit) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.res_sel    = SEL_OVERFLOW;
          state_next     = S_DONE;
        end else if (stat.scan_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          cmd.res_sel    = SEL_NONE;
          state_next     = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_OVF_RD;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hash_table_with_overflow_area.sv =====
// Keyed table with a primary area and an overflow area. One transaction in
// gives exactly one transaction out. A key hashes to its primary slot as the
// byte sum modulo PRIMARY_SLOTS, worked out by a reciprocal multiplication
// for the quotient, then a multiply-subtract for the remainder. An insert,
// and a search answered without the overflow area, go on to a read and a
// check of the primary slot and then to the result; a search that misses the
// primary slot then reads and checks the overflow entries, if any, one at a
// time through the single read port of the overflow store, until a hit or the
// last entry. Items are handled one at a time; a finished result sits in the
// output register while the next key is taken in, and a stalled output holds
// the following result back and the input with it. No clearing pass is needed
// after reset.
`default_nettype none

module hash_table_with_overflow_area #(
  parameter int unsigned PRIMARY_SLOTS  = htoa_pkg::DEF_PRIMARY_SLOTS,
  parameter int unsigned OVERFLOW_SLOTS = htoa_pkg::DEF_OVERFLOW_SLOTS,
  parameter int unsigned KEY_CHARS      = htoa_pkg::DEF_KEY_CHARS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        operation,
  input  wire logic [htoa_pkg::KEY_W-1:0]  key,
  input  wire logic [htoa_pkg::REC_W-1:0]  record_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [htoa_pkg::STATUS_W-1:0]    status,
  output logic [htoa_pkg::REC_W-1:0]       result_index
);
  import htoa_pkg::*;

`include "hash_table_with_overflow_area_macros.svh"

  htoa_cmd_t  cmd;
  htoa_stat_t stat;
  logic       found_set;

  // sequencer
  htoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // stores and arithmetic
  htoa_dp #(
    .PRIMARY_SLOTS  (PRIMARY_SLOTS),
    .OVERFLOW_SLOTS (OVERFLOW_SLOTS),
    .KEY_CHARS      (KEY_CHARS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .key          (key),
    .record_index (record_index),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .status       (status),
    .result_index (result_index)
  );

  assign found_set = cmd.res_set && (cmd.res_status == ST_FOUND);

  // checks on the sequencing
  `HTOA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `HTOA_ASSERT_IMP(a_load_when_free, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `HTOA_ASSERT_IMP(a_found_on_search, found_set, stat.op_search, "insert reported found")
  `HTOA_ASSERT_IMP(a_status_code, out_valid, status <= ST_NOT_FOUND, "bad status code")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the hash table with overflow area: directed rows, then random traffic
`timescale 1ns / 100ps

module tb;
  import htoa_pkg::*;

  localparam int unsigned N_PRIMARY  = DEF_PRIMARY_SLOTS;
  localparam int unsigned N_OVERFLOW = DEF_OVERFLOW_SLOTS;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PAUSE_AT     = 800;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 500000;

  // one directed row; typed marks a row whose answer is written out here
  typedef struct {
    logic             op;
    logic [KEY_W-1:0] k;
    logic [REC_W-1:0] rec;
    bit               typed;
    status_t          st;
    logic [REC_W-1:0] idx;
  } stim_row_t;

  typedef struct {
    status_t          st;
    logic [REC_W-1:0] idx;
  } lookup_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             operation = OP_INSERT;
  logic [KEY_W-1:0] key = '0;
  logic [REC_W-1:0] record_index = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [REC_W-1:0] result_index;

  // shadow copy of the table contents
  bit               prim_used [N_PRIMARY];
  logic [KEY_W-1:0] prim_key  [N_PRIMARY];
  logic [REC_W-1:0] prim_rec  [N_PRIMARY];
  logic [KEY_W-1:0] ovf_key   [N_OVERFLOW];
  logic [REC_W-1:0] ovf_rec   [N_OVERFLOW];
  int unsigned      ovf_count = 0;

  lookup_result_t   pending_results[$];
  logic [KEY_W-1:0] inserted_keys[$];
  int               failures = 0;
  int               results_seen = 0;
  int               cycle_count = 0;

  // directed rows: empty slots, extremes, duplicates, high bytes, overflow full
  stim_row_t directed_rows [23] = '{
    '{OP_SEARCH, 64'h0,                  8'hAA, 1'b1, ST_NOT_FOUND, 8'h00},
    '{OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h55, 1'b1, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h0,                  8'hFF, 1'b1, ST_PRIMARY,   8'h00},
    '{OP_SEARCH, 64'h0,                  8'h00, 1'b1, ST_FOUND,     8'hFF},
    '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, ST_OVERFLOW,  8'h00},
    '{OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, ST_FOUND,     8'h00},
    '{OP_INSERT, 64'h41,                 8'h12, 1'b1, ST_PRIMARY,   8'h00},
    '{OP_INSERT, 64'h41,                 8'h34, 1'b1, ST_OVERFLOW,  8'h00},
    '{OP_SEARCH, 64'h41,                 8'h00, 1'b1, ST_FOUND,     8'h12},
    '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'h56, 1'b1, ST_OVERFLOW,  8'h00},
    '{OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, ST_FOUND,     8'h00},
    '{OP_INSERT, 64'h82,                 8'h9A, 1'b1, ST_PRIMARY,   8'h00},
    '{OP_SEARCH, 64'h82,                 8'h00, 1'b1, ST_FOUND,     8'h9A},
    '{OP_SEARCH, 64'h0101,               8'h00, 1'b0, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h08,                 8'h01, 1'b0, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h10,                 8'h02, 1'b0, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h18,                 8'h03, 1'b0, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h20,                 8'h04, 1'b0, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h28,                 8'h05, 1'b0, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h30,                 8'h06, 1'b1, ST_FULL,      8'h00},
    '{OP_SEARCH, 64'h30,                 8'h00, 1'b1, ST_NOT_FOUND, 8'h00},
    '{OP_SEARCH, 64'h28,                 8'h00, 1'b0, ST_NOT_FOUND, 8'h00},
    '{OP_INSERT, 64'h41,                 8'h77, 1'b1, ST_FULL,      8'h00}
  };

  hash_table_with_overflow_area #(
    .PRIMARY_SLOTS (N_PRIMARY),
    .OVERFLOW_SLOTS(N_OVERFLOW),
    .KEY_CHARS     (DEF_KEY_CHARS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .key         (key),
    .record_index(record_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .result_index(result_index)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // applies one insert or search to the shadow table and gives its answer
  function automatic void apply_table_op(input logic op, input logic [KEY_W-1:0] k,
                                         input logic [REC_W-1:0] rec,
                                         output status_t st, output logic [REC_W-1:0] idx);
    int unsigned byte_sum;
    int unsigned slot;
    byte_sum = 0;
    for (int b = 0; b < KEY_W / 8; b++) byte_sum += 32'(k[8*b +: 8]);
    slot = byte_sum % N_PRIMARY;
    idx = '0;
    if (op == OP_INSERT) begin
      if (!prim_used[slot]) begin
        prim_used[slot] = 1'b1;
        prim_key[slot] = k;
        prim_rec[slot] = rec;
        st = ST_PRIMARY;
      end else if (ovf_count < N_OVERFLOW) begin
        ovf_key[ovf_count] = k;
        ovf_rec[ovf_count] = rec;
        ovf_count++;
        st = ST_OVERFLOW;
      end else begin
        st = ST_FULL;
      end
    end else begin
      st = ST_NOT_FOUND;
      if (prim_used[slot] && prim_key[slot] == k) begin
        st = ST_FOUND;
        idx = prim_rec[slot];
      end else begin
        // earliest overflow copy wins
        for (int i = 0; i < int'(ovf_count); i++) begin
          if (st != ST_FOUND && ovf_key[i] == k) begin
            st = ST_FOUND;
            idx = ovf_rec[i];
          end
        end
      end
    end
  endfunction

  // random key: full-width noise, a single byte, or a short ascii string
  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    int len;
    k = '0;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: k = KEY_W'($urandom_range(0, 255));
      default: begin
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(32, 126));
      end
    endcase
    return k;
  endfunction

  // offers one transaction and records its expected answer once accepted
  task automatic offer_item(input logic op, input logic [KEY_W-1:0] k,
                            input logic [REC_W-1:0] rec, input bit no_gap,
                            input bit typed, input status_t t_st,
                            input logic [REC_W-1:0] t_idx);
    int gap;
    lookup_result_t exp_res;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    key          <= k;
    record_index <= rec;
    do @(posedge clk); while (!in_ready);
    apply_table_op(op, k, rec, exp_res.st, exp_res.idx);
    if (typed) begin
      exp_res.st  = t_st;
      exp_res.idx = t_idx;
    end
    if (op == OP_INSERT) inserted_keys.push_back(k);
    pending_results.push_back(exp_res);
  endtask

  // compares one accepted result with the oldest expectation
  task automatic check_result(input status_t got_st, input logic [REC_W-1:0] got_idx);
    lookup_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d result_index %0d", got_st, got_idx);
      failures++;
    end else begin
      exp_res = pending_results.pop_front();
      if (got_st !== exp_res.st) begin
        $error("status: expected %0d, actual %0d", exp_res.st, got_st);
        failures++;
      end
      if (got_idx !== exp_res.idx) begin
        $error("result_index: expected %0d, actual %0d", exp_res.idx, got_idx);
        failures++;
      end
    end
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_side
    int hold;
    bit calm;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        check_result(status_t'(status), result_index);
        results_seen++;
        calm = ((results_seen / 130) % 5) == 2;
        hold = calm ? 0 : $urandom_range(0, 6);
        if (results_seen == HOLD_AT) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus side
  initial begin : stimulus
    logic             op;
    logic [KEY_W-1:0] k;
    bit               calm;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (directed_rows[r])
      offer_item(directed_rows[r].op, directed_rows[r].k, directed_rows[r].rec, 1'b0,
                 directed_rows[r].typed, directed_rows[r].st, directed_rows[r].idx);

    // random traffic, searches mostly for keys already inserted
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      calm = ((n / 100) % 5) == 4;
      op = ($urandom_range(0, 99) < 45) ? OP_INSERT : OP_SEARCH;
      if (op == OP_SEARCH && inserted_keys.size() != 0 && $urandom_range(0, 2) != 0)
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      else
        k = random_key();
      offer_item(op, k, REC_W'($urandom), calm, 1'b0, ST_NOT_FOUND, '0);
    end
    in_valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
